/* rtl/lfpid_pkg.sv */
// Shared types and constants for the line follower PID drive.
package lfpid_pkg;

  localparam int unsigned RefreshMsDef  = 10;
  localparam int unsigned SampleBitsDef = 10;

  localparam int unsigned DivW   = 43;
  localparam int unsigned DvsW   = 32;
  localparam int unsigned CntW   = $clog2(DivW);

  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegGainP     = 3'd1;
  localparam logic [2:0] RegGainI     = 3'd2;
  localparam logic [2:0] RegGainD     = 3'd3;
  localparam logic [2:0] RegIntLimit  = 3'd4;
  localparam logic [2:0] RegNominal   = 3'd5;
  localparam logic [2:0] RegSearch    = 3'd6;
  localparam logic [2:0] RegSpeedLim  = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    StIdle,
    StCent,
    StCentWait,
    StDue,
    StDivI,
    StDivIWait,
    StDivD,
    StDivDWait,
    StMulP,
    StMulI,
    StMulD,
    StScale,
    StDrive,
    StOut
  } state_e;

endpackage

/* rtl/lfpid_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module lfpid_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [lfpid_pkg::DivW-1:0]       dividend_i,
  input  logic [lfpid_pkg::DvsW-1:0]       divisor_i,
  output logic [lfpid_pkg::DivW-1:0]       quotient_o,
  output lfpid_pkg::div_status_t           status_o
);

  logic [lfpid_pkg::DivW-1:0] dvd_q;
  logic [lfpid_pkg::DvsW-1:0] dvs_q;
  logic [lfpid_pkg::DvsW-1:0] rem_q, rem_d;
  logic [lfpid_pkg::CntW-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic [lfpid_pkg::DvsW:0]   shifted;
  logic                       ge;

  always_comb begin
    shifted = {rem_q, dvd_q[lfpid_pkg::DivW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? lfpid_pkg::DvsW'(shifted - {1'b0, dvs_q})
                 : shifted[lfpid_pkg::DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == lfpid_pkg::CntW'(lfpid_pkg::DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[lfpid_pkg::DivW-2:0], ge};
    end
  end

  assign quotient_o    = dvd_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

/* rtl/line_follower_pid_drive.sv */
// Top level: line follower centroid error, PID correction and H-bridge drive.
//
// One item is taken at a time: in_stall_o is high from the input transfer until the
// result is loaded into the output register. out_valid_o rises soonest when no analog
// sensor sees line, later when line is seen but the PID step is not due, and latest
// when the PID step runs; a stalled output register holds the result back in StOut.
// The order of steps is set by the bit-serial divider, which is started, shifts out
// its quotient bits and then reports done. It is used once for the centroid and
// twice more (integral step, derivative) when the PID step is due, followed by three
// multiply-accumulate steps, scale and drive. A finished result waits in the output
// register while the next item is already taken.
module line_follower_pid_drive #(
  parameter int unsigned REFRESH_MS  = lfpid_pkg::RefreshMsDef,
  parameter int unsigned SAMPLE_BITS = lfpid_pkg::SampleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        edge_sensor_level_i,
  input  logic [9:0]  reading_a_i,
  input  logic [9:0]  reading_b_i,
  input  logic [9:0]  reading_c_i,
  input  logic [9:0]  reading_d_i,
  input  logic [9:0]  reading_e_i,
  input  logic [9:0]  reading_f_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  left_forward_pwm_o,
  output logic [7:0]  left_reverse_pwm_o,
  output logic [7:0]  right_forward_pwm_o,
  output logic [7:0]  right_reverse_pwm_o,
  output logic        line_seen_o
);

  localparam logic [9:0] SampleMask =
    (SAMPLE_BITS >= 10) ? 10'h3FF : 10'((1 << SAMPLE_BITS) - 1);

  // configuration
  logic [9:0]  thr_q;
  logic [15:0] kp_q, ki_q, kd_q, ilim_q;
  logic [7:0]  nom_q, srch_q, slim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 10'd512;
      kp_q   <= 16'd256;
      ki_q   <= 16'd0;
      kd_q   <= 16'd0;
      ilim_q <= 16'd2560;
      nom_q  <= 8'd150;
      srch_q <= 8'd120;
      slim_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lfpid_pkg::RegThreshold: thr_q  <= cfg_wdata_i[9:0];
        lfpid_pkg::RegGainP:     kp_q   <= cfg_wdata_i;
        lfpid_pkg::RegGainI:     ki_q   <= cfg_wdata_i;
        lfpid_pkg::RegGainD:     kd_q   <= cfg_wdata_i;
        lfpid_pkg::RegIntLimit:  ilim_q <= cfg_wdata_i;
        lfpid_pkg::RegNominal:   nom_q  <= cfg_wdata_i[7:0];
        lfpid_pkg::RegSearch:    srch_q <= cfg_wdata_i[7:0];
        lfpid_pkg::RegSpeedLim:  slim_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // centroid terms at transfer in
  logic [5:0]        hit;
  logic signed [4:0] num_c;
  logic [2:0]        den_c;

  always_comb begin
    hit[0] = (reading_a_i & SampleMask) <= thr_q;
    hit[1] = (reading_b_i & SampleMask) <= thr_q;
    hit[2] = (reading_c_i & SampleMask) <= thr_q;
    hit[3] = (reading_d_i & SampleMask) <= thr_q;
    hit[4] = (reading_e_i & SampleMask) <= thr_q;
    hit[5] = (reading_f_i & SampleMask) <= thr_q;
    num_c = (edge_sensor_level_i ? 5'sd0 : -5'sd4)
          + (hit[0] ? -5'sd2 : 5'sd0) + (hit[1] ? -5'sd1 : 5'sd0)
          + (hit[3] ? 5'sd1 : 5'sd0) + (hit[4] ? 5'sd2 : 5'sd0)
          + (hit[5] ? 5'sd4 : 5'sd0);
    den_c = 3'(!edge_sensor_level_i) + 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2])
          + 3'(hit[3]) + 3'(hit[4]) + 3'(hit[5]);
  end

  lfpid_pkg::state_e state_q, state_d;

  logic signed [4:0]  num_q;
  logic [2:0]         den_q;
  logic               seen_q;
  logic [31:0]        now_q;
  logic signed [11:0] err_q, last_err_q, prev_err_q;
  logic signed [23:0] isum_q;
  logic [31:0]        last_time_q, e_q;
  logic [42:0]        prod_q;
  logic signed [16:0] integ_q;
  logic signed [21:0] deriv_q;
  logic               dneg_q;
  logic signed [41:0] acc_q;
  logic signed [25:0] corr_q;
  logic [7:0]         lf_q, lr_q, rf_q, rr_q;
  logic               out_valid_q, seen_out_q;
  logic [7:0]         lf_o_q, lr_o_q, rf_o_q, rr_o_q;

  // divider hookup
  logic                     div_start;
  logic [42:0]              div_dvd;
  logic [31:0]              div_dvs;
  logic [42:0]              div_quo;
  lfpid_pkg::div_status_t   div_st;

  lfpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  logic [4:0]         abs_num;
  logic [10:0]        abs_err;
  logic signed [12:0] diff;
  logic [11:0]        abs_diff;
  logic [31:0]        e_c;
  logic               due;
  logic signed [11:0] err_c;
  logic signed [34:0] step_c, integ_c, ilim_c;
  logic signed [16:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [39:0] mul_p;
  logic signed [26:0] left_c, right_c;
  logic               load_out;

  always_comb begin
    abs_num  = num_q[4] ? 5'(-num_q) : 5'(num_q);
    abs_err  = err_q[11] ? 11'(-err_q) : 11'(err_q);
    diff     = 13'(err_q) - 13'(prev_err_q);
    abs_diff = diff[12] ? 12'(-diff) : 12'(diff);
    e_c      = now_q - last_time_q;
    due      = (e_c != 32'd0) && (e_c >= 32'(REFRESH_MS));
    err_c    = num_q[4] ? -$signed({1'b0, div_quo[10:0]}) : $signed({1'b0, div_quo[10:0]});
    step_c   = err_q[11] ? -$signed({2'b0, div_quo[32:0]}) : $signed({2'b0, div_quo[32:0]});
    integ_c  = 35'(isum_q) + step_c;
    ilim_c   = $signed({19'b0, ilim_q});
    if (integ_c > ilim_c) integ_c = ilim_c;
    else if (integ_c < -ilim_c) integ_c = -ilim_c;
  end

  // shared multiplier for the three gain terms
  always_comb begin
    case (state_q)
      lfpid_pkg::StMulI: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = 23'(integ_q);
      end
      lfpid_pkg::StMulD: begin
        mul_a = $signed({1'b0, kd_q});
        mul_b = 23'(deriv_q);
      end
      default: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = 23'(err_q);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    if (seen_q) begin
      left_c  = $signed({19'b0, nom_q}) + 27'(corr_q);
      right_c = $signed({19'b0, nom_q}) - 27'(corr_q);
    end else if (last_err_q > 12'sd0) begin
      left_c  = $signed({19'b0, srch_q});
      right_c = -$signed({19'b0, srch_q});
    end else if (last_err_q < 12'sd0) begin
      left_c  = -$signed({19'b0, srch_q});
      right_c = $signed({19'b0, srch_q});
    end else begin
      left_c  = '0;
      right_c = '0;
    end
  end

  function automatic logic [15:0] drive_split(input logic signed [26:0] cmd,
                                              input logic [7:0] lim);
    logic signed [26:0] l;
    logic signed [26:0] v;
    l = $signed({19'b0, lim});
    v = cmd;
    if (v > l) v = l;
    else if (v < -l) v = -l;
    if (v < 27'sd0) drive_split = {8'd0, 8'(-v)};
    else drive_split = {8'(v), 8'd0};
  endfunction

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = {30'b0, abs_num, 8'b0};
    div_dvs   = {29'b0, den_q};
    load_out  = 1'b0;
    case (state_q)
      lfpid_pkg::StIdle:
        if (in_valid_i) state_d = lfpid_pkg::StCent;
      lfpid_pkg::StCent: begin
        div_start = 1'b1;
        state_d   = lfpid_pkg::StCentWait;
      end
      lfpid_pkg::StCentWait:
        if (div_st.done) state_d = seen_q ? lfpid_pkg::StDue : lfpid_pkg::StDrive;
      lfpid_pkg::StDue:
        state_d = due ? lfpid_pkg::StDivI : lfpid_pkg::StDrive;
      lfpid_pkg::StDivI: begin
        div_start = 1'b1;
        div_dvd   = prod_q;
        div_dvs   = 32'd1000;
        state_d   = lfpid_pkg::StDivIWait;
      end
      lfpid_pkg::StDivIWait:
        if (div_st.done) state_d = lfpid_pkg::StDivD;
      lfpid_pkg::StDivD: begin
        div_start = 1'b1;
        div_dvd   = 43'(abs_diff * 22'd1000);
        div_dvs   = e_q;
        state_d   = lfpid_pkg::StDivDWait;
      end
      lfpid_pkg::StDivDWait:
        if (div_st.done) state_d = lfpid_pkg::StMulP;
      lfpid_pkg::StMulP: state_d = lfpid_pkg::StMulI;
      lfpid_pkg::StMulI: state_d = lfpid_pkg::StMulD;
      lfpid_pkg::StMulD: state_d = lfpid_pkg::StScale;
      lfpid_pkg::StScale: state_d = lfpid_pkg::StDrive;
      lfpid_pkg::StDrive: state_d = lfpid_pkg::StOut;
      lfpid_pkg::StOut:
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = lfpid_pkg::StIdle;
        end
      default: state_d = lfpid_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfpid_pkg::StIdle;
      last_err_q  <= '0;
      prev_err_q  <= '0;
      isum_q      <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lfpid_pkg::StCentWait && div_st.done && seen_q) last_err_q <= err_c;
      if (state_q == lfpid_pkg::StDivIWait && div_st.done) isum_q <= 24'(integ_c);
      if (state_q == lfpid_pkg::StDivDWait && div_st.done) begin
        prev_err_q  <= err_q;
        last_time_q <= now_q;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lfpid_pkg::StIdle && in_valid_i) begin
      num_q  <= num_c;
      den_q  <= den_c;
      seen_q <= |hit;
      now_q  <= now_ms_i;
    end
    case (state_q)
      lfpid_pkg::StCentWait: if (div_st.done) err_q <= err_c;
      lfpid_pkg::StDue: begin
        e_q    <= e_c;
        prod_q <= 43'(abs_err) * 43'(e_c);
        corr_q <= '0;
      end
      lfpid_pkg::StDivIWait: if (div_st.done) integ_q <= 17'(integ_c);
      lfpid_pkg::StDivD: dneg_q <= diff[12];
      lfpid_pkg::StDivDWait:
        if (div_st.done) begin
          deriv_q <= dneg_q ? -$signed({1'b0, div_quo[20:0]})
                            : $signed({1'b0, div_quo[20:0]});
          acc_q   <= '0;
        end
      lfpid_pkg::StMulP, lfpid_pkg::StMulI, lfpid_pkg::StMulD:
        acc_q <= acc_q + 42'(mul_p);
      lfpid_pkg::StScale:
        corr_q <= acc_q[41] ? 26'((acc_q + 42'sd65535) >>> 16) : 26'(acc_q >>> 16);
      lfpid_pkg::StDrive: begin
        {lf_q, lr_q} <= drive_split(left_c, slim_q);
        {rf_q, rr_q} <= drive_split(right_c, slim_q);
      end
      default: ;
    endcase
    if (load_out) begin
      lf_o_q     <= lf_q;
      lr_o_q     <= lr_q;
      rf_o_q     <= rf_q;
      rr_o_q     <= rr_q;
      seen_out_q <= seen_q;
    end
  end

  assign in_stall_o          = state_q != lfpid_pkg::StIdle;
  assign out_valid_o         = out_valid_q;
  assign left_forward_pwm_o  = lf_o_q;
  assign left_reverse_pwm_o  = lr_o_q;
  assign right_forward_pwm_o = rf_o_q;
  assign right_reverse_pwm_o = rr_o_q;
  assign line_seen_o         = seen_out_q;

endmodule

/* dv/tb_line_follower_pid_drive.sv */
// Self-checking testbench for line_follower_pid_drive with a PID drive scoreboard.
`timescale 1ns / 100ps

module tb_line_follower_pid_drive;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct {
    logic        edge_lvl;
    logic [9:0]  rd [6];
    logic [31:0] now;
  } tick_t;

  typedef struct {
    logic [7:0] lf;
    logic [7:0] lr;
    logic [7:0] rf;
    logic [7:0] rr;
    logic       seen;
  } drive_t;

  class drive_scoreboard;
    int          wt [7] = '{-4, -2, -1, 0, 1, 2, 4};
    longint      thr, kp, ki, kd, ilim, nominal, search, slim;
    int          last_err, prev_err;
    longint      integ_sum;
    logic [31:0] last_time;
    drive_t      pending_drive [$];
    int          fails;

    function new();
      thr = 512; kp = 256; ki = 0; kd = 0; ilim = 2560;
      nominal = 150; search = 120; slim = 255;
      last_err = 0; prev_err = 0; integ_sum = 0; last_time = '0; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        lfpid_pkg::RegThreshold: thr = longint'(val[9:0]);
        lfpid_pkg::RegGainP:     kp = longint'(val);
        lfpid_pkg::RegGainI:     ki = longint'(val);
        lfpid_pkg::RegGainD:     kd = longint'(val);
        lfpid_pkg::RegIntLimit:  ilim = longint'(val);
        lfpid_pkg::RegNominal:   nominal = longint'(val[7:0]);
        lfpid_pkg::RegSearch:    search = longint'(val[7:0]);
        lfpid_pkg::RegSpeedLim:  slim = longint'(val[7:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint pid_correction(int err, logic [31:0] now);
      logic [31:0] el32;
      longint el, integ, deriv, acc;
      el32 = now - last_time;
      el = {32'b0, el32};
      if (el == 0 || el < lfpid_pkg::RefreshMsDef) return 0;
      integ = clamp(integ_sum + (longint'(err) * el) / 1000, ilim);
      integ_sum = integ;
      deriv = (longint'(err - prev_err) * 1000) / el;
      prev_err = err;
      last_time = now;
      acc = kp * err + ki * integ + kd * deriv;
      return acc / 65536;
    endfunction

    function drive_t split(longint left, longint right, logic seen);
      drive_t d;
      left = clamp(left, slim);
      right = clamp(right, slim);
      d.lf = left >= 0 ? left[7:0] : 8'd0;
      d.lr = left < 0 ? 8'(-left) : 8'd0;
      d.rf = right >= 0 ? right[7:0] : 8'd0;
      d.rr = right < 0 ? 8'(-right) : 8'd0;
      d.seen = seen;
      return d;
    endfunction

    function void note_tick(tick_t t);
      int num, den, err;
      logic seen;
      longint corr;
      num = 0; den = 0; seen = 1'b0;
      if (!t.edge_lvl) begin
        num += wt[0];
        den += 1;
      end
      for (int i = 0; i < 6; i++) begin
        if (t.rd[i] <= thr) begin
          num += wt[i + 1];
          den += 1;
          seen = 1'b1;
        end
      end
      if (seen) begin
        err = (num * 256) / den;
        last_err = err;
        corr = pid_correction(err, t.now);
        pending_drive.push_back(split(nominal + corr, nominal - corr, 1'b1));
      end else if (last_err > 0) begin
        pending_drive.push_back(split(search, -search, 1'b0));
      end else if (last_err < 0) begin
        pending_drive.push_back(split(-search, search, 1'b0));
      end else begin
        pending_drive.push_back(split(0, 0, 1'b0));
      end
    endfunction

    task report(string what, int got, int want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      fails++;
    endtask

    task check_drive(drive_t got);
      drive_t want;
      if (pending_drive.size() == 0) begin
        report("unexpected transfer", 1, 0);
        return;
      end
      want = pending_drive.pop_front();
      if (got.lf !== want.lf) report("left_forward_pwm", got.lf, want.lf);
      if (got.lr !== want.lr) report("left_reverse_pwm", got.lr, want.lr);
      if (got.rf !== want.rf) report("right_forward_pwm", got.rf, want.rf);
      if (got.rr !== want.rr) report("right_reverse_pwm", got.rr, want.rr);
      if (got.seen !== want.seen) report("line_seen", got.seen, want.seen);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        edge_sensor_level_i = 1'b1;
  logic [9:0]  reading_a_i = '0, reading_b_i = '0, reading_c_i = '0;
  logic [9:0]  reading_d_i = '0, reading_e_i = '0, reading_f_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  left_forward_pwm_o, left_reverse_pwm_o;
  logic [7:0]  right_forward_pwm_o, right_reverse_pwm_o;
  logic        line_seen_o;

  drive_scoreboard sb = new();
  bit          quiet = 1'b0;
  int          out_wait = 0;
  int unsigned cycles = 0;
  logic [31:0] clock_ms = '0;

  line_follower_pid_drive dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // input transfers feed the predictor
  always @(posedge clk_i) begin
    tick_t t;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      t.edge_lvl = edge_sensor_level_i;
      t.rd = '{reading_a_i, reading_b_i, reading_c_i, reading_d_i, reading_e_i, reading_f_i};
      t.now = now_ms_i;
      sb.note_tick(t);
    end
  end

  // output transfers are checked; stall drawn per result
  always @(posedge clk_i) begin
    drive_t d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      d = '{left_forward_pwm_o, left_reverse_pwm_o, right_forward_pwm_o,
            right_reverse_pwm_o, line_seen_o};
      sb.check_drive(d);
      out_wait = quiet ? 0 : $urandom_range(0, 5);
    end
    if (out_wait > 0) begin
      out_stall_i <= 1'b1;
      out_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task send_tick(tick_t t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    edge_sensor_level_i <= t.edge_lvl;
    {reading_a_i, reading_b_i, reading_c_i} <= {t.rd[0], t.rd[1], t.rd[2]};
    {reading_d_i, reading_e_i, reading_f_i} <= {t.rd[3], t.rd[4], t.rd[5]};
    now_ms_i <= t.now;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task drain;
    in_valid_i <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_regs(logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= 3'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function tick_t make_tick(logic e, logic [9:0] v [6], logic [31:0] now);
    tick_t t;
    t.edge_lvl = e;
    t.rd = v;
    t.now = now;
    return t;
  endfunction

  function tick_t random_tick();
    tick_t t;
    int mode;
    longint th;
    th = sb.thr;
    mode = $urandom_range(0, 9);
    t.edge_lvl = 1'($urandom_range(0, 1));
    for (int i = 0; i < 6; i++) begin
      if (mode == 0) t.rd[i] = 10'($urandom_range(0, 1023));
      else if (mode != 1 && $urandom_range(0, 2) == 0) t.rd[i] = 10'($urandom_range(0, 32'(th)));
      else if (th < 1023) t.rd[i] = 10'($urandom_range(32'(th + 1), 1023));
      else t.rd[i] = 10'($urandom_range(0, 1023));
    end
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 25);
    t.now = clock_ms;
    return t;
  endfunction

  logic [15:0] phase_regs [5][8] = '{
    '{16'd300, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd255, 16'd255, 16'd255},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd1023, 16'd400, 16'd300, 16'd500, 16'd0, 16'd200, 16'd50, 16'd100},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd512, 16'd1024, 16'd128, 16'd64, 16'd2560, 16'd150, 16'd120, 16'd255}
  };

  initial begin
    logic [9:0] v [6];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks at reset settings
    send_tick(make_tick(1'b0, '{0, 0, 0, 0, 0, 0}, 32'd0));
    send_tick(make_tick(1'b1, '{1023, 1023, 1023, 1023, 1023, 1023}, 32'd3));
    send_tick(make_tick(1'b0, '{1023, 1023, 1023, 1023, 1023, 1023}, 32'd6));
    for (int i = 0; i < 6; i++) begin
      v = '{1023, 1023, 1023, 1023, 1023, 1023};
      v[i] = (i % 2) ? 10'd512 : 10'd0;
      send_tick(make_tick(i[0], v, 32'd20 + 32'(i) * 12));
    end
    send_tick(make_tick(1'b1, '{1023, 1023, 1023, 1023, 1023, 1023}, 32'd100));
    send_tick(make_tick(1'b0, '{0, 0, 1023, 1023, 1023, 1023}, 32'd105));
    send_tick(make_tick(1'b1, '{0, 513, 513, 513, 513, 513}, 32'd200));
    send_tick(make_tick(1'b1, '{1023, 1023, 1023, 1023, 1023, 1023}, 32'd201));
    send_tick(make_tick(1'b1, '{513, 513, 513, 513, 513, 0}, 32'hFFFF_FFF0));
    send_tick(make_tick(1'b0, '{1023, 1023, 1023, 1023, 0, 0}, 32'h0000_0005));
    send_tick(make_tick(1'b1, '{1023, 1023, 1023, 1023, 1023, 1023}, 32'h0000_0009));
    send_tick(make_tick(1'b0, '{511, 512, 513, 1023, 0, 1}, 32'h8000_0000));
    send_tick(make_tick(1'b0, '{511, 512, 513, 1023, 0, 1}, 32'h8000_0000));
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p == 3) begin
        for (int i = 0; i < 8; i++) phase_regs[3][i] = 16'($urandom_range(0, 65535));
      end
      write_regs(phase_regs[p]);
      quiet = (p == 2);
      for (int n = 0; n < 170; n++) send_tick(random_tick());
      drain();
    end

    quiet = 1'b0;
    repeat (200) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending_drive.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
